### rtl/tcw_pkg.sv
`default_nettype none
package tcw_pkg;

    // default geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // field widths
    localparam int CMD_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int IDX_W    = 11;
    localparam int POS_W    = 11;
    localparam int ROW_W    = 5;
    localparam int COL_W    = 7;
    localparam int CELL_W   = 16;
    localparam int ATTR_W   = 8;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 40;
    localparam int APB_AW   = 2;
    localparam int APB_DW   = 32;

    // commands
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // register map
    localparam logic [APB_AW-1:0] ADDR_ATTR = 2'd0;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_GLYPH  = 8'h20;
    localparam logic [ATTR_W-1:0] DEF_ATTR     = 8'h07;
    localparam logic [CELL_W-1:0] CLEAR_CELL   = 16'h0720;

endpackage
`default_nettype wire

### rtl/text_console_cell_writer.sv
`default_nettype none
// Text console over a ROWS x COLUMNS store of 16-bit cells (attribute in the high byte,
// glyph in the low byte). Each request on s_axis gives exactly one result on m_axis.
// A printable put or a newline goes straight to the result state, a read via ST_READ. A put
// that runs off the bottom row scrolls the store, reading each cell one row down and
// writing it back (ST_SCR_RD, ST_SCR_WR), then blanking the bottom row (ST_BLANK).
// A clear writes one cell a cycle. After reset the store is initialised in a clearing
// pass during which s_axis_tready stays low; the attribute register may be written over
// APB at any time the console is idle.
module text_console_cell_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] char_code, [18:8] cell_index, [23:19] zero
    input  wire logic [tcw_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // [1:0] cmd
    input  wire logic [tcw_pkg::CMD_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [10:0] cursor_position, [15:11] cursor_row, [22:16] cursor_col,
    // [23] scrolled, [39:24] cell_data
    output logic      [tcw_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tcw_pkg::APB_AW-1:0]    paddr,
    input  wire logic [tcw_pkg::APB_DW-1:0]    pwdata,
    output logic      [tcw_pkg::APB_DW-1:0]    prdata,
    output logic                               pready
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    logic [ATTR_W-1:0] attr;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    tcw_apb u_apb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .attr    (attr)
    );

    tcw_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .CELLS   (CELLS),
        .AW      (AW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .cmd        (s_axis_tuser),
        .char_code  (s_axis_tdata[CHAR_W-1:0]),
        .cell_index (s_axis_tdata[CHAR_W+IDX_W-1:CHAR_W]),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_data     (m_axis_tdata),
        .attr       (attr),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

endmodule
`default_nettype wire

### rtl/tcw_apb.sv
`default_nettype none
module tcw_apb (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tcw_pkg::APB_AW-1:0]   paddr,
    input  wire logic [tcw_pkg::APB_DW-1:0]   pwdata,
    output logic      [tcw_pkg::APB_DW-1:0]   prdata,
    output logic                              pready,
    output logic      [tcw_pkg::ATTR_W-1:0]   attr
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0] attr_reg;
    logic [ATTR_W-1:0] attr_next;
    logic              wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && pready && (paddr == ADDR_ATTR);

    always_comb begin
        attr_next = attr_reg;
        if (wr_hit) begin
            attr_next = pwdata[ATTR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= DEF_ATTR;
        end else begin
            attr_reg <= attr_next;
        end
    end

    assign prdata = (paddr == ADDR_ATTR) ? APB_DW'(attr_reg) : '0;
    assign attr   = attr_reg;

endmodule
`default_nettype wire

### rtl/tcw_ram.sv
`default_nettype none
module tcw_ram #(
    parameter int DEPTH = tcw_pkg::DEF_ROWS * tcw_pkg::DEF_COLUMNS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                        aclk,
    input  wire logic                        we,
    input  wire logic [AW-1:0]               waddr,
    input  wire logic [tcw_pkg::CELL_W-1:0]  wdata,
    input  wire logic                        re,
    input  wire logic [AW-1:0]               raddr,
    output logic      [tcw_pkg::CELL_W-1:0]  rdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### rtl/tcw_ctrl.sv
`default_nettype none
module tcw_ctrl #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS,
    parameter int CELLS   = ROWS * COLUMNS,
    parameter int AW      = $clog2(CELLS)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [tcw_pkg::CMD_W-1:0]     cmd,
    input  wire logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  wire logic [tcw_pkg::IDX_W-1:0]     cell_index,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [tcw_pkg::M_DATA_W-1:0]  m_data,
    input  wire logic [tcw_pkg::ATTR_W-1:0]    attr,
    output logic                               ram_we,
    output logic      [AW-1:0]                 ram_waddr,
    output logic      [tcw_pkg::CELL_W-1:0]    ram_wdata,
    output logic                               ram_re,
    output logic      [AW-1:0]                 ram_raddr,
    input  wire logic [tcw_pkg::CELL_W-1:0]    ram_rdata
);
    import tcw_pkg::*;

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS);

    localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
    localparam logic [AW-1:0] LAST_COPY   = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0] BOTTOM_ROW  = AW'(CELLS - COLUMNS);
    localparam logic [RW-1:0] LAST_ROW    = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL    = CW'(COLUMNS - 1);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_CLEAR  = 3'd3;
    localparam logic [2:0] ST_SCR_RD = 3'd4;
    localparam logic [2:0] ST_SCR_WR = 3'd5;
    localparam logic [2:0] ST_BLANK  = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       ctr_reg, ctr_next;
    logic [RW-1:0]       row_reg, row_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic                scr_reg, scr_next;
    logic                rd_ok_reg, rd_ok_next;
    logic [CELL_W-1:0]   data_reg, data_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic                accept;
    logic                in_range;
    logic                load_out;
    logic [AW-1:0]       addend;
    logic [AW-1:0]       sum;
    logic [AW-1:0]       nl_pos;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign in_range = (32'(cell_index) < CELLS);
    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // shared address unit: next cell for sweeps, source row for the scroll copy
    assign addend = (state_reg == ST_SCR_RD) ? AW'(COLUMNS) : AW'(1);
    assign sum    = ctr_reg + addend;
    assign nl_pos = pos_reg + (AW'(COLUMNS) - AW'(col_reg));

    always_comb begin
        state_next   = state_reg;
        ctr_next     = ctr_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        pos_next     = pos_reg;
        scr_next     = scr_reg;
        rd_ok_next   = rd_ok_reg;
        data_next    = data_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = ctr_reg;
        ram_wdata    = CLEAR_CELL;
        ram_re       = 1'b0;
        ram_raddr    = sum;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT: begin
                ram_we = 1'b1;
                ctr_next = sum;
                if (ctr_reg == LAST_CELL) begin
                    ctr_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    scr_next   = 1'b0;
                    data_next  = '0;
                    state_next = ST_DONE;
                    unique case (cmd)
                        CMD_PUT: begin
                            if (char_code == NEWLINE_CODE) begin
                                col_next = '0;
                                row_next = row_reg + RW'(1);
                                pos_next = nl_pos;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = pos_reg;
                                ram_wdata = {attr, char_code};
                                pos_next  = pos_reg + AW'(1);
                                if (col_reg == LAST_COL) begin
                                    col_next = '0;
                                    row_next = row_reg + RW'(1);
                                end else begin
                                    col_next = col_reg + CW'(1);
                                end
                            end
                            // wrap or newline off the bottom row
                            if ((row_reg == LAST_ROW) &&
                                ((char_code == NEWLINE_CODE) || (col_reg == LAST_COL))) begin
                                row_next   = LAST_ROW;
                                col_next   = '0;
                                pos_next   = BOTTOM_ROW;
                                scr_next   = 1'b1;
                                ctr_next   = '0;
                                state_next = ST_SCR_RD;
                            end
                        end
                        CMD_CLEAR: begin
                            row_next   = '0;
                            col_next   = '0;
                            pos_next   = '0;
                            ctr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        CMD_READ: begin
                            ram_re     = in_range;
                            ram_raddr  = AW'(cell_index);
                            rd_ok_next = in_range;
                            state_next = ST_READ;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                data_next  = rd_ok_reg ? ram_rdata : '0;
                state_next = ST_DONE;
            end
            ST_CLEAR: begin
                ram_we   = 1'b1;
                ctr_next = sum;
                if (ctr_reg == LAST_CELL) begin
                    ctr_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_SCR_RD: begin
                ram_re     = 1'b1;
                state_next = ST_SCR_WR;
            end
            ST_SCR_WR: begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                ctr_next   = sum;
                state_next = (ctr_reg == LAST_COPY) ? ST_BLANK : ST_SCR_RD;
            end
            ST_BLANK: begin
                ram_we    = 1'b1;
                ram_wdata = {attr, BLANK_GLYPH};
                ctr_next  = sum;
                if (ctr_reg == LAST_CELL) begin
                    ctr_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {data_reg, scr_reg, COL_W'(col_reg),
                                    ROW_W'(row_reg), POS_W'(pos_reg)};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            ctr_reg     <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ctr_reg     <= ctr_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scr_reg    <= scr_next;
        rd_ok_reg  <= rd_ok_next;
        data_reg   <= data_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // cursor never leaves the store
    a_pos_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(pos_reg) < CELLS)
        else $error("cursor beyond store");

    // linear position tracks row and column
    a_pos_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(pos_reg) == 32'(row_reg) * COLUMNS + 32'(col_reg))
        else $error("cursor position out of step with row/column");

    // no request is taken during a sweep
    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INIT || state_reg == ST_CLEAR || state_reg == ST_SCR_RD ||
         state_reg == ST_SCR_WR || state_reg == ST_BLANK) |-> !s_ready)
        else $error("ready during store sweep");

    // a scroll reports the start of the bottom row
    a_scroll_home: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && scr_reg) |-> (pos_reg == BOTTOM_ROW))
        else $error("scroll left cursor off the bottom row start");

    // requests are never accepted back to back
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("request accepted back to back");
`endif

endmodule
`default_nettype wire
